// File: hdl/base64_text_decoder_assert.svh
// assertion macros used by the base64 text decoder back end
// expects a clock named clk and a synchronous reset named rst in the including module
`ifndef BASE64_TEXT_DECODER_ASSERT_SVH
`define BASE64_TEXT_DECODER_ASSERT_SVH

// checked outside reset only
`define B64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define B64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/b64td_pkg.sv
// shared types, constants and character classification for the base64 text decoder
// no dependencies
`default_nettype none

package b64td_pkg;

  localparam logic [7:0] QMARK = 8'h3F;
  localparam logic [7:0] PAD   = 8'h3D;

  localparam int GRPQ_DEPTH = 4;
  localparam int GRPQ_AW    = $clog2(GRPQ_DEPTH);

  // one decoded group: byte 0 in the top bits, keep[0] goes with byte 0
  typedef struct packed {
    logic [23:0] bytes;
    logic [2:0]  keep;
  } grp_t;

  // {bad, 6-bit value}; pad counts as zero
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'h00;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      r = {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      r = {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      r = {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end else if (c == PAD) begin
      r = 7'h00;
    end
    return r;
  endfunction

  function automatic logic is_fold_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

endpackage

`default_nettype wire

// File: hdl/b64td_front.sv
// front end: accepts text bytes, drops whitespace, gathers groups of four
// depends on b64td_pkg
`default_nettype none

module b64td_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [7:0]     s_tdata,
  input  wire logic           s_tlast,
  input  wire logic           q_full,
  output logic                q_push,
  output b64td_pkg::grp_t     q_data
);
  import b64td_pkg::*;

  logic [1:0]  held_count;
  logic [5:0]  held_val [3];
  logic        held_pad1;
  logic        held_pad2;
  logic        held_bad;

  logic        acc;
  logic        ws;
  logic [6:0]  cls;
  logic        grp_done;
  logic        grp_bad;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;
  assign ws       = is_fold_ws(s_tdata);
  assign cls      = sextet(s_tdata);
  assign grp_done = acc && !ws && (held_count == 2'd3);
  assign grp_bad  = held_bad || cls[6];

  always_comb begin
    if (grp_bad) begin
      q_data.bytes = {QMARK, QMARK, QMARK};
      q_data.keep  = 3'b111;
    end else begin
      q_data.bytes = {held_val[0], held_val[1], held_val[2], cls[5:0]};
      q_data.keep  = {s_tdata != PAD, !held_pad2, !held_pad1};
    end
  end

  assign q_push = grp_done && (q_data.keep != 3'b000);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (acc) begin
      if (s_tlast || grp_done) begin
        held_count <= 2'd0;
      end else if (!ws) begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  // character slots, no reset needed: count says which are live
  always_ff @(posedge clk) begin
    if (acc && !ws && held_count != 2'd3) begin
      held_val[held_count] <= cls[5:0];
      if (held_count == 2'd0) begin
        held_bad <= cls[6];
      end else begin
        held_bad <= held_bad || cls[6];
      end
      if (held_count == 2'd1) begin
        held_pad1 <= (s_tdata == PAD);
      end
      if (held_count == 2'd2) begin
        held_pad2 <= (s_tdata == PAD);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64td_grpq.sv
// short queue of decoded groups between front and back
// depends on b64td_pkg
`default_nettype none

module b64td_grpq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64td_pkg::grp_t wr_data,
  output logic                full,
  input  wire logic           pop,
  output logic                rd_valid,
  output b64td_pkg::grp_t     rd_data
);
  import b64td_pkg::*;

  grp_t                  slots [GRPQ_DEPTH];
  logic [GRPQ_AW-1:0]    wr_ptr;
  logic [GRPQ_AW-1:0]    rd_ptr;
  logic [GRPQ_AW:0]      count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count == (GRPQ_AW+1)'(GRPQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64td_back.sv
// back end: takes groups from the queue and sends their bytes one per cycle while the receiver is ready
// depends on b64td_pkg and base64_text_decoder_assert.svh
`default_nettype none
`include "base64_text_decoder_assert.svh"

module b64td_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire b64td_pkg::grp_t q_data,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import b64td_pkg::*;

  logic [23:0] cur_bytes;
  logic [2:0]  cur_mask;
  logic [2:0]  mask_left;
  logic [7:0]  sel_byte;
  logic        adv;

  // lowest set bit of the mask picks the byte
  always_comb begin
    if (cur_mask[0]) begin
      sel_byte  = cur_bytes[23:16];
      mask_left = {cur_mask[2:1], 1'b0};
    end else if (cur_mask[1]) begin
      sel_byte  = cur_bytes[15:8];
      mask_left = {cur_mask[2], 2'b00};
    end else begin
      sel_byte  = cur_bytes[7:0];
      mask_left = 3'b000;
    end
  end

  assign adv   = (cur_mask != 3'b000) && (!m_tvalid || m_tready);
  assign q_pop = q_valid && ((cur_mask == 3'b000) || (adv && mask_left == 3'b000));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= 3'b000;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_mask <= q_data.keep;
      end else if (adv) begin
        cur_mask <= mask_left;
      end
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bytes <= q_data.bytes;
    end
    if (adv) begin
      m_tdata <= sel_byte;
      m_tlast <= (mask_left == 3'b000);
    end
  end

  `B64_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "output valid right after reset")
  `B64_ASSERT(a_rest_held, (m_tvalid && m_tready && !m_tlast) |-> (cur_mask != 3'b000),
              "group bytes lost before run end")
  `B64_ASSERT(a_pop_busy, (q_pop && cur_mask != 3'b000) |-> (adv && mask_left == 3'b000),
              "group taken while current one unfinished")
  `B64_ASSERT(a_pop_nonempty, q_pop |=> (cur_mask != 3'b000),
              "empty group loaded")

endmodule

`default_nettype wire

// File: hdl/base64_text_decoder.sv
// top level of the streaming base64 text decoder
// depends on b64td_pkg, b64td_front, b64td_grpq, b64td_back
//
// input stream (s_*): one encoded text byte per request; s_tlast marks the
// final byte of a text, after which any partial group is dropped.
// output stream (m_*): one decoded byte per request; m_tlast marks the last
// byte produced by a group of four characters. groups holding a byte above
// 127 or outside the alphabet produce three '?' bytes.
// whitespace (space, tab, cr, lf) is skipped and produces nothing.
// after the fourth character is accepted, the group is written into the queue,
// loaded by the back end and its first byte registered on the output.
// throughput: one input byte per cycle while the queue is not full; the back
// end sends one byte per cycle while the receiver is ready.
// a four-entry group queue sits between front and back; when the receiver
// stalls the queue fills and s_tready drops only once it is full.
// reset (rst, synchronous) empties the queue, the output register and the
// partial group.
`default_nettype none

module base64_text_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  input  wire logic       s_tlast,   // end_of_text
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // run_end
);
  import b64td_pkg::*;

  // front to queue
  logic  q_full;
  logic  q_push;
  grp_t  q_wr;

  // queue to back
  logic  q_valid;
  logic  q_pop;
  grp_t  q_rd;

  // classify characters and build groups
  b64td_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  // decouples character intake from byte output
  b64td_grpq u_grpq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  // serialize the kept bytes of each group
  b64td_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// File: sim/b64td_decode_check.sv
// watches both streams of the base64 text decoder, predicts the decoded bytes and compares
// depends on b64td_pkg for the pad and question-mark codes
`timescale 1ns / 100ps

module b64td_decode_check (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] text_byte
  input  wire logic       s_tlast,   // end_of_text
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,   // [7:0] out_byte
  input  wire logic       m_tlast,   // run_end
  output int              failures,
  output int              bytes_pending,
  output int              bytes_checked
);
  import b64td_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_byte_t;

  decoded_byte_t decoded_q[$];
  logic [7:0]    group_chars [3] = '{8'h00, 8'h00, 8'h00};
  int unsigned   group_fill = 0;
  int            err_cnt = 0;
  int            ok_cnt = 0;

  initial begin
    failures = 0;
    bytes_pending = 0;
    bytes_checked = 0;
  end

  function automatic bit is_folding_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // {invalid, 6-bit value}; anything above 127 falls out as invalid
  function automatic logic [6:0] char_code(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= "A" && c <= "Z") v = c - "A";
    else if (c >= "a" && c <= "z") v = c - "a" + 8'd26;
    else if (c >= "0" && c <= "9") v = c - "0" + 8'd52;
    else if (c == "+") v = 8'd62;
    else if (c == "/") v = 8'd63;
    else if (c == PAD) v = 8'd0;
    return (v == 8'hFF) ? 7'h40 : {1'b0, v[5:0]};
  endfunction

  task automatic predict_text_byte(input logic [7:0] c, input logic eot);
    logic [7:0]    chars [4];
    logic [6:0]    code;
    logic [23:0]   bits;
    logic          bad;
    decoded_byte_t run[$];
    if (!is_folding_space(c)) begin
      if (group_fill < 3) begin
        group_chars[group_fill] = c;
        group_fill++;
      end else begin
        chars = '{group_chars[0], group_chars[1], group_chars[2], c};
        group_fill = 0;
        bad = 1'b0;
        bits = '0;
        for (int k = 0; k < 4; k++) begin
          code = char_code(chars[k]);
          bad |= code[6];
          bits = {bits[17:0], code[5:0]};
        end
        if (bad) begin
          repeat (3) run.push_back('{QMARK, 1'b0});
        end else begin
          // a pad in the second, third or fourth slot drops the byte it would end
          if (chars[1] != PAD) run.push_back('{bits[23:16], 1'b0});
          if (chars[2] != PAD) run.push_back('{bits[15:8], 1'b0});
          if (chars[3] != PAD) run.push_back('{bits[7:0], 1'b0});
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) decoded_q.push_back(run[i]);
      end
    end
    // end of text throws away whatever partial group is left
    if (eot) group_fill = 0;
  endtask

  always @(posedge clk) begin : watch
    decoded_byte_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected byte: expected none, got data %h last %b",
                   $time, m_tdata, m_tlast);
          err_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: out_byte mismatch: expected %h, got %h", $time, want.data, m_tdata);
            err_cnt++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: run_end mismatch: expected %b, got %b", $time, want.last, m_tlast);
            err_cnt++;
          end
        end
        ok_cnt++;
      end
      if (s_tvalid && s_tready) predict_text_byte(s_tdata, s_tlast);
      failures      <= err_cnt;
      bytes_checked <= ok_cnt;
      bytes_pending <= decoded_q.size();
    end
  end

endmodule

// File: sim/tb_base64_text_decoder.sv
// top of the base64 text decoder testbench: clock, reset, text stimulus and output backpressure
// depends on base64_text_decoder, b64td_pkg and the b64td_decode_check monitor
`timescale 1ns / 100ps

module tb_base64_text_decoder;
  import b64td_pkg::*;

  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] TAB   = 8'h09;
  localparam logic [7:0] CR    = 8'h0D;
  localparam logic [7:0] LF    = 8'h0A;
  localparam int TOTAL_ITEMS   = 110;
  localparam int LONG_HOLD     = 120;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] text_byte
  logic       s_tlast = 1'b0;    // end_of_text
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // run_end

  int failures;
  int bytes_pending;
  int bytes_checked;

  // sender side bookkeeping
  bit src_gaps = 1'b0;
  int text_items = 0;
  int space_items = 0;

  always #5 clk = ~clk;

  base64_text_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  b64td_decode_check decode_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .failures      (failures),
    .bytes_pending (bytes_pending),
    .bytes_checked (bytes_checked)
  );

  // mostly no gap, some short ones, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] alphabet_char();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, 63));
    if (idx < 26) return "A" + idx;
    if (idx < 52) return "a" + idx - 8'd26;
    if (idx < 62) return "0" + idx - 8'd52;
    return (idx == 62) ? "+" : "/";
  endfunction

  function automatic logic [7:0] folding_space();
    case ($urandom_range(0, 3))
      0: return SPACE;
      1: return TAB;
      2: return CR;
      default: return LF;
    endcase
  endfunction

  // one request on the input stream; returns at the edge where it is taken
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    if (c == SPACE || c == TAB || c == CR || c == LF) space_items++;
    else text_items++;
  endtask

  // first n characters of a group, leftmost first, with stray whitespace mixed in
  task automatic send_group(input logic [31:0] g, input int n, input logic eot);
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      c = g[31 - 8 * k -: 8];
      if (src_gaps && $urandom_range(0, 5) == 0) send_char(folding_space(), 1'b0);
      send_char(c, eot && (k == n - 1));
    end
  endtask

  // output side: random stalls in phases, plus one long hold-off to fill the group queue
  initial begin : sink
    int  hold_left;
    int  phase_left;
    bit  sink_stalls;
    bit  long_hold_done;
    hold_left = 0;
    phase_left = 0;
    sink_stalls = 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        sink_stalls = $urandom_range(0, 2) != 0;
        phase_left = $urandom_range(50, 200);
      end else begin
        phase_left--;
      end
      if (!long_hold_done && bytes_checked >= 15) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && sink_stalls && $urandom_range(0, 3) == 0) begin
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [31:0] g;
    int          kind;
    int          groups;
    groups = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: plain group, single and no-byte pad groups, pad in front
    send_group("TWFu", 4, 1'b0);
    send_group("TQ==", 4, 1'b0);
    send_group("A===", 4, 1'b0);
    send_group("=/+9", 4, 1'b0);
    // all-ones and all-zeros bytes plus a high byte make a bad group; lf is skipped inside
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(LF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char("a", 1'b0);
    // partial group dropped by end of text on a whitespace byte
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char(TAB, 1'b1);
    // partial group dropped by end of text on a real character
    send_char("Z", 1'b0);
    send_char(SPACE, 1'b0);
    send_char("z", 1'b1);

    // random: mostly well-formed groups, some padded, some broken or noisy
    while (text_items + space_items < TOTAL_ITEMS) begin
      if (groups % 12 == 0) src_gaps = $urandom_range(0, 3) != 0;
      groups++;
      g = {alphabet_char(), alphabet_char(), alphabet_char(), alphabet_char()};
      kind = $urandom_range(0, 19);
      case (kind)
        12, 13: g[7:0] = PAD;
        14: g[15:0] = {PAD, PAD};
        15: g[23:0] = {PAD, PAD, PAD};
        16: g[8 * $urandom_range(0, 3) +: 8] = 8'($urandom_range(0, 255));
        17: g[8 * $urandom_range(0, 3) +: 8] = 8'h80 | 8'($urandom_range(0, 127));
        default: ;
      endcase
      if (kind >= 18) begin
        send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_group(g, $urandom_range(1, 3), 1'b1);
      end else begin
        send_group(g, 4, $urandom_range(0, 7) == 0);
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // let the monitor count the last accepted request before draining
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d text bytes and %0d folding whitespace bytes, gaps on both sides",
             text_items, space_items);
    $display("%0d decoded bytes checked, with one %0d-cycle output hold-off",
             bytes_checked, LONG_HOLD);
    if (failures == 0 && bytes_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // safety net far above the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("%0t: timeout, %0d bytes still expected", $time, bytes_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/b64td_pkg.sv
hdl/b64td_front.sv
hdl/b64td_grpq.sv
hdl/b64td_back.sv
hdl/base64_text_decoder.sv
sim/b64td_decode_check.sv
sim/tb_base64_text_decoder.sv
